### rtl/tmia_pkg.sv
// Package for the triangle minimum interior angle block: word types, datapath widths
// and the arctangent constants used by the CORDIC stages.
// Standalone; every other file in rtl/ imports it.
package tmia_pkg;

  // Coordinate and datapath widths
  localparam int COORD_WIDTH = 16;
  localparam int EDGE_W      = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * EDGE_W;
  localparam int LEN_W       = SQ_W + 2;
  localparam int VEC_W       = EDGE_W + 1;
  localparam int PROD_W      = 2 * VEC_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int MAG_W       = SUM_W;
  localparam int BL_W        = $clog2(MAG_W + 1);
  localparam int NORM_BITS   = 30;
  localparam int SQN_W       = 2 * NORM_BITS;
  localparam int SQRT_STEPS  = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int Q_SHIFT     = 24;
  localparam int T36_W       = 38;
  localparam int MIN_ANGLE_W = 14;
  localparam logic [31:0] MAX_ANGLE = 32'((1 << MIN_ANGLE_W) - 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;
  } tmia_in_t;

  typedef struct packed {
    logic [MIN_ANGLE_W-1:0] min_angle;
    logic                   degenerate;
  } tmia_out_t;

  // Odd series divisors and odd powers of three for the arctangent series
  localparam logic [63:0] ODD_DIV [30] = '{
    64'd1,  64'd3,  64'd5,  64'd7,  64'd9,  64'd11, 64'd13, 64'd15, 64'd17, 64'd19,
    64'd21, 64'd23, 64'd25, 64'd27, 64'd29, 64'd31, 64'd33, 64'd35, 64'd37, 64'd39,
    64'd41, 64'd43, 64'd45, 64'd47, 64'd49, 64'd51, 64'd53, 64'd55, 64'd57, 64'd59
  };

  localparam logic [63:0] POW3 [19] = '{
    64'd3, 64'd27, 64'd243, 64'd2187, 64'd19683, 64'd177147, 64'd1594323,
    64'd14348907, 64'd129140163, 64'd1162261467, 64'd10460353203,
    64'd94143178827, 64'd847288609443, 64'd7625597484987, 64'd68630377364883,
    64'd617673396283947, 64'd5559060566555523, 64'd50031545098999707,
    64'd450283905890997363
  };

  // atan(2^-i) in Q60, each series term truncated
  function automatic logic [63:0] atan_pow2(int unsigned i);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] t;
    p = 64'd1 << (60 - i);
    s = '0;
    for (int k = 0; k < 30; k++) begin
      t = (p >> (2 * i * k)) / ODD_DIV[k];
      if (k[0]) s = s - t;
      else s = s + t;
    end
    return s;
  endfunction

  // atan(1/3) in Q60, each series term truncated
  function automatic logic [63:0] atan_third();
    logic [63:0] s;
    logic [63:0] t;
    s = '0;
    for (int k = 0; k < 19; k++) begin
      t = ((64'd1 << 60) / POW3[k]) / ODD_DIV[k];
      if (k[0]) s = s - t;
      else s = s + t;
    end
    return s;
  endfunction

  // CORDIC rotation angle for step i; step 0 is atan(1/2) + atan(1/3)
  function automatic logic [63:0] atan_tab(int unsigned i);
    if (i == 0) return atan_pow2(1) + atan_third();
    return atan_pow2(i);
  endfunction

  localparam logic [63:0]        ATAN_ONE  = atan_tab(0);
  localparam logic signed [63:0] PI60      = signed'(ATAN_ONE << 2);
  localparam logic signed [63:0] HALF_PI60 = signed'(ATAN_ONE << 1);
  localparam logic [63:0]        PI36      = ATAN_ONE >> (Q_SHIFT - 2);

endpackage

### rtl/triangle_min_interior_angle.sv
// Top level of the triangle minimum interior angle block: a fully pipelined datapath
// from edge vectors through square root, CORDIC and constant division.
// Depends on tmia_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one triangle per word
//   (three vertices, signed 16-bit coordinates). Output channel out_valid_o /
//   out_stall_i / out_data_o carries the smallest interior angle in degrees with
//   ANGLE_FRAC_BITS fraction bits, rounded to nearest, and a degenerate flag.
//   A word moves when valid is high and stall is low at a rising clock edge.
// Pipeline: 11 front stages, 32 square-root steps, 32 CORDIC steps, 3 scaling and
//   division stages and the output register.
// Throughput: one triangle per cycle while the output is not stalled; each pipeline
//   stage takes a new word every cycle unless the pipeline holds.
// Reset clears all valid bits; no word is in flight afterward and payload registers
//   hold stale data that is never shown.
// When the receiver stalls a valid output word, the whole pipeline holds in place and
//   in_stall_o is raised in the same cycle; nothing is dropped or repeated.
module triangle_min_interior_angle
  import tmia_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tmia_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tmia_out_t out_data_o
);

  localparam int FRONT  = 11;
  localparam int QUOT_W = ANGLE_FRAC_BITS + 8;
  localparam int RCP_SH = 32;
  localparam int TH_LSB = 6;
  localparam int LAT    = FRONT + SQRT_STEPS + CORDIC_STEPS + 3 + 1;
  localparam logic [63:0] ANG_SCALE = 64'd360 << ANGLE_FRAC_BITS;
  localparam logic [63:0] DIVISOR   = PI36 << 1;
  // Reciprocal of the divisor, scaled for the truncated angle and the product shift
  localparam logic [63:0] RECIP     = (ANG_SCALE << (RCP_SH + TH_LSB)) / DIVISOR;
  localparam logic [63:0] RND_HALF  = 64'd1 << (RCP_SH - 1);

  // Pipeline advance and valid tracking
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Stage 1: edge vectors AB, AC, BC
  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic signed [COORD_WIDTH-1:0] pc [3];
  logic signed [EDGE_W-1:0]      e1_q [3][3];

  assign pa[0] = in_data_i.vertex_a_x;
  assign pa[1] = in_data_i.vertex_a_y;
  assign pa[2] = in_data_i.vertex_a_z;
  assign pb[0] = in_data_i.vertex_b_x;
  assign pb[1] = in_data_i.vertex_b_y;
  assign pb[2] = in_data_i.vertex_b_z;
  assign pc[0] = in_data_i.vertex_c_x;
  assign pc[1] = in_data_i.vertex_c_y;
  assign pc[2] = in_data_i.vertex_c_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[0][i] <= EDGE_W'(pb[i]) - EDGE_W'(pa[i]);
        e1_q[1][i] <= EDGE_W'(pc[i]) - EDGE_W'(pa[i]);
        e1_q[2][i] <= EDGE_W'(pc[i]) - EDGE_W'(pb[i]);
      end
    end
  end

  // Stage 2: squared components and zero-edge detection
  logic signed [SQ_W-1:0]   sq2_q [3][3];
  logic signed [EDGE_W-1:0] e2_q  [3][3];
  logic signed [EDGE_W-1:0] e3_q  [3][3];
  logic [FRONT:2]           dg_q;
  logic [2:0]               zero_edge;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      zero_edge[j] = (e1_q[j][0] == '0) && (e1_q[j][1] == '0) && (e1_q[j][2] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          sq2_q[j][i] <= e1_q[j][i] * e1_q[j][i];
          e2_q[j][i]  <= e1_q[j][i];
          e3_q[j][i]  <= e2_q[j][i];
        end
      end
      dg_q[2] <= |zero_edge;
      for (int k = 3; k <= FRONT; k++) begin
        dg_q[k] <= dg_q[k-1];
      end
    end
  end

  // Stage 3: squared edge lengths
  logic signed [LEN_W-1:0] len3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        len3_q[j] <= LEN_W'(sq2_q[j][0]) + LEN_W'(sq2_q[j][1]) + LEN_W'(sq2_q[j][2]);
      end
    end
  end

  // Edge select stage: take both edges that meet at the vertex opposite the shortest edge
  logic signed [VEC_W-1:0] u4_q [3];
  logic signed [VEC_W-1:0] w4_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        priority if (len3_q[2] <= len3_q[1] && len3_q[2] <= len3_q[0]) begin
          u4_q[i] <= VEC_W'(e3_q[0][i]);
          w4_q[i] <= VEC_W'(e3_q[1][i]);
        end else if (len3_q[1] <= len3_q[0]) begin
          u4_q[i] <= -VEC_W'(e3_q[0][i]);
          w4_q[i] <= VEC_W'(e3_q[2][i]);
        end else begin
          u4_q[i] <= VEC_W'(e3_q[1][i]);
          w4_q[i] <= VEC_W'(e3_q[2][i]);
        end
      end
    end
  end

  // Stage 5: dot and cross partial products
  logic signed [PROD_W-1:0] pd5_q [3];
  logic signed [PROD_W-1:0] pc5_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd5_q[i] <= u4_q[i] * w4_q[i];
      end
      pc5_q[0] <= u4_q[1] * w4_q[2];
      pc5_q[1] <= u4_q[2] * w4_q[1];
      pc5_q[2] <= u4_q[2] * w4_q[0];
      pc5_q[3] <= u4_q[0] * w4_q[2];
      pc5_q[4] <= u4_q[0] * w4_q[1];
      pc5_q[5] <= u4_q[1] * w4_q[0];
    end
  end

  // Stage 6: dot product and cross product components
  logic signed [SUM_W-1:0] s6_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q[0] <= SUM_W'(pc5_q[0]) - SUM_W'(pc5_q[1]);
      s6_q[1] <= SUM_W'(pc5_q[2]) - SUM_W'(pc5_q[3]);
      s6_q[2] <= SUM_W'(pc5_q[4]) - SUM_W'(pc5_q[5]);
      s6_q[3] <= SUM_W'(pd5_q[0]) + SUM_W'(pd5_q[1]) + SUM_W'(pd5_q[2]);
    end
  end

  // Stage 7: magnitudes; keep the dot product sign
  logic [MAG_W-1:0] mg7_q [4];
  logic [MAG_W-1:0] mg8_q [4];
  logic [FRONT:7]   dn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mg7_q[i] <= s6_q[i][SUM_W-1] ? $unsigned(-s6_q[i]) : $unsigned(s6_q[i]);
        mg8_q[i] <= mg7_q[i];
      end
      dn_q[7] <= s6_q[3][SUM_W-1];
      for (int k = 8; k <= FRONT; k++) begin
        dn_q[k] <= dn_q[k-1];
      end
    end
  end

  // Stage 8: bit length of the largest magnitude (same as of their OR)
  logic [MAG_W-1:0] mag_or;
  logic [BL_W-1:0]  bl;
  logic [BL_W-1:0]  bl8_q;

  assign mag_or = mg7_q[0] | mg7_q[1] | mg7_q[2] | mg7_q[3];

  always_comb begin
    bl = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mag_or[b]) bl = BL_W'(b + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bl8_q <= bl;
    end
  end

  // Stage 9: normalize all four magnitudes to NORM_BITS bits
  logic [MAG_W-1:0]     nrm [4];
  logic [NORM_BITS-1:0] cn9_q [3];
  logic [NORM_BITS-1:0] ad9_q;
  logic [NORM_BITS-1:0] ad10_q;
  logic [NORM_BITS-1:0] ad11_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (bl8_q > BL_W'(NORM_BITS)) nrm[i] = mg8_q[i] >> (bl8_q - BL_W'(NORM_BITS));
      else nrm[i] = mg8_q[i] << (BL_W'(NORM_BITS) - bl8_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cn9_q[i] <= nrm[i][NORM_BITS-1:0];
      end
      ad9_q  <= nrm[3][NORM_BITS-1:0];
      ad10_q <= ad9_q;
      ad11_q <= ad10_q;
    end
  end

  // Stage 10: squares of the normalized cross components
  logic [SQN_W-1:0] sqc10_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqc10_q[i] <= SQN_W'(cn9_q[i]) * SQN_W'(cn9_q[i]);
      end
    end
  end

  // Stage 11: squared cross product length
  logic [63:0] csq11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      csq11_q <= 64'(sqc10_q[0]) + 64'(sqc10_q[1]) + 64'(sqc10_q[2]);
    end
  end

  // Integer square root, one result bit per stage
  logic [63:0]          sqn_q [SQRT_STEPS];
  logic [63:0]          sqr_q [SQRT_STEPS];
  logic [NORM_BITS-1:0] sqa_q [SQRT_STEPS];
  logic                 sqg_q [SQRT_STEPS];
  logic                 sqd_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]          n_in;
    logic [63:0]          res_in;
    logic [63:0]          trial;
    logic [NORM_BITS-1:0] ad_in;
    logic                 dg_in;
    logic                 dn_in;

    if (k == 0) begin : g_first
      assign n_in   = csq11_q;
      assign res_in = '0;
      assign ad_in  = ad11_q;
      assign dg_in  = dg_q[FRONT];
      assign dn_in  = dn_q[FRONT];
    end else begin : g_next
      assign n_in   = sqn_q[k-1];
      assign res_in = sqr_q[k-1];
      assign ad_in  = sqa_q[k-1];
      assign dg_in  = sqg_q[k-1];
      assign dn_in  = sqd_q[k-1];
    end

    assign trial = res_in + BIT;

    // Try this bit of the root; keep it when the remainder allows
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (n_in >= trial) begin
          sqn_q[k] <= n_in - trial;
          sqr_q[k] <= (res_in >> 1) + BIT;
        end else begin
          sqn_q[k] <= n_in;
          sqr_q[k] <= res_in >> 1;
        end
        sqa_q[k] <= ad_in;
        sqg_q[k] <= dg_in;
        sqd_q[k] <= dn_in;
      end
    end
  end

  // CORDIC vectoring, one rotation per stage
  logic signed [63:0] cx_q [CORDIC_STEPS];
  logic signed [63:0] cy_q [CORDIC_STEPS];
  logic signed [63:0] cz_q [CORDIC_STEPS];
  logic               crz_q [CORDIC_STEPS];
  logic               caz_q [CORDIC_STEPS];
  logic               cg_q  [CORDIC_STEPS];
  logic               cd_q  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [63:0] ANG = signed'(atan_tab(i));
    logic signed [63:0] x_in;
    logic signed [63:0] y_in;
    logic signed [63:0] z_in;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic               rz_in;
    logic               az_in;
    logic               dg_in;
    logic               dn_in;

    if (i == 0) begin : g_first
      assign x_in  = signed'(64'(sqa_q[SQRT_STEPS-1]) << Q_SHIFT);
      assign y_in  = signed'(sqr_q[SQRT_STEPS-1] << Q_SHIFT);
      assign z_in  = '0;
      assign rz_in = (sqr_q[SQRT_STEPS-1] == '0);
      assign az_in = (sqa_q[SQRT_STEPS-1] == '0);
      assign dg_in = sqg_q[SQRT_STEPS-1];
      assign dn_in = sqd_q[SQRT_STEPS-1];
    end else begin : g_next
      assign x_in  = cx_q[i-1];
      assign y_in  = cy_q[i-1];
      assign z_in  = cz_q[i-1];
      assign rz_in = crz_q[i-1];
      assign az_in = caz_q[i-1];
      assign dg_in = cg_q[i-1];
      assign dn_in = cd_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!y_in[63]) begin
          cx_q[i] <= x_in + ys;
          cy_q[i] <= y_in - xs;
          cz_q[i] <= z_in + ANG;
        end else begin
          cx_q[i] <= x_in - ys;
          cy_q[i] <= y_in + xs;
          cz_q[i] <= z_in - ANG;
        end
        crz_q[i] <= rz_in;
        caz_q[i] <= az_in;
        cg_q[i]  <= dg_in;
        cd_q[i]  <= dn_in;
      end
    end
  end

  // Post stage 1: special angles, clamp, obtuse fold, cut to Q36
  logic signed [63:0] zc;
  logic signed [63:0] zf;
  logic signed [63:0] z_end;
  logic [T36_W-1:0]   t36_q;
  logic               pg1_q;

  assign z_end = cz_q[CORDIC_STEPS-1];

  always_comb begin
    priority if (crz_q[CORDIC_STEPS-1]) begin
      zc = '0;
    end else if (caz_q[CORDIC_STEPS-1]) begin
      zc = HALF_PI60;
    end else if (z_end[63]) begin
      zc = '0;
    end else if (z_end > HALF_PI60) begin
      zc = HALF_PI60;
    end else begin
      zc = z_end;
    end
    zf = cd_q[CORDIC_STEPS-1] ? PI60 - zc : zc;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t36_q <= zf[Q_SHIFT +: T36_W];
      pg1_q <= cg_q[CORDIC_STEPS-1];
    end
  end

  // Post stage 2: scale to degrees with the rounding half, and estimate the quotient
  // by the reciprocal; the estimate is the exact quotient or one below it
  logic [63:0] num_q;
  logic [63:0] est_q;
  logic        pg2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= 64'(t36_q) * ANG_SCALE + PI36;
      est_q <= 64'(t36_q[T36_W-1:TH_LSB]) * RECIP + RND_HALF;
      pg2_q <= pg1_q;
    end
  end

  // Post stage 3: remainder of the estimate against 2*pi
  logic [QUOT_W-1:0] q_est;
  logic [QUOT_W-1:0] q3_q;
  logic [63:0]       rem3_q;
  logic              pg3_q;

  assign q_est = est_q[RCP_SH +: QUOT_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      q3_q   <= q_est;
      rem3_q <= num_q - 64'(q_est) * DIVISOR;
      pg3_q  <= pg2_q;
    end
  end

  // Output register: correct the estimate, saturate, force zero on degenerate triangles
  logic [31:0] q_ext;
  tmia_out_t   out_q;

  assign q_ext = 32'(q3_q) + ((rem3_q >= DIVISOR) ? 32'd1 : 32'd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.degenerate <= pg3_q;
      if (pg3_q) begin
        out_q.min_angle <= '0;
      end else if (q_ext > MAX_ANGLE) begin
        out_q.min_angle <= MAX_ANGLE[MIN_ANGLE_W-1:0];
      end else begin
        out_q.min_angle <= q_ext[MIN_ANGLE_W-1:0];
      end
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_data_o  = out_q;

endmodule

### rtl/tmia_checker.sv
// Port-level checker for the triangle minimum interior angle block, with its bind.
// Depends on tmia_pkg and on triangle_min_interior_angle.
module tmia_checker
  import tmia_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input tmia_out_t out_data_o
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed or dropped");

  // Stall the input exactly when the output word is held
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output back-pressure");

  // Degenerate triangles report a zero angle
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.min_angle == '0)
    else $error("degenerate word carries a nonzero angle");

  // No output word in the cycle after reset releases
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output word present right after reset");

endmodule

bind triangle_min_interior_angle tmia_checker u_tmia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
